### sv/wakeup_timer_queue_assert.svh
// Assertion macros for the wakeup timer queue.
// Used by the top level only; depends on a clock i_clk and reset i_rst_n in scope.
`ifndef WAKEUP_TIMER_QUEUE_ASSERT_SVH
`define WAKEUP_TIMER_QUEUE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define WTQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define WTQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### sv/wtq_pkg.sv
// Shared types and constants for the wakeup timer queue.
// No dependencies; imported by every module of the block.
package wtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 48;
    localparam int ID_WIDTH_DEF    = 8;

    typedef enum logic [1:0] {
        REQ_SCHEDULE = 2'd0,
        REQ_ADVANCE  = 2'd1,
        REQ_HALT     = 2'd2,
        REQ_RESET    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_SCHED = 2'd0,
        KIND_WAKE  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_HALTED = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

endpackage

### sv/wtq_front.sv
// Front end of the wakeup timer queue: accepts requests and queues them.
// Depends on wtq_pkg.
module wtq_front
    import wtq_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [TIME_WIDTH-1:0] i_wake_time,
    input  logic [ID_WIDTH-1:0]   i_requester_id,
    input  logic [TIME_WIDTH-1:0] i_time_increment,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_pop,
    output t_req                  o_cmd_type,
    output logic [TIME_WIDTH-1:0] o_cmd_time,
    output logic [ID_WIDTH-1:0]   o_cmd_id
);

    t_req                  r_type [2];
    logic [TIME_WIDTH-1:0] r_time [2];
    logic [ID_WIDTH-1:0]   r_id   [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_fill;
    logic                  push;
    logic                  pop;
    t_req                  req;

    assign req         = t_req'(i_req_type);
    assign o_stall     = (r_fill == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_type  = r_type[r_rd_ptr];
    assign o_cmd_time  = r_time[r_rd_ptr];
    assign o_cmd_id    = r_id[r_rd_ptr];

    // An advance carries its increment in the time slot; other requests carry the wake time.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_type[r_wr_ptr] <= req;
            r_time[r_wr_ptr] <= (req == REQ_ADVANCE) ? i_time_increment : i_wake_time;
            r_id[r_wr_ptr]   <= i_requester_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

### sv/wtq_engine.sv
// Back end of the wakeup timer queue: time keeping, sorted request list, result register.
// Depends on wtq_pkg.
module wtq_engine
    import wtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    input  t_req                  i_cmd_type,
    input  logic [TIME_WIDTH-1:0] i_cmd_time,
    input  logic [ID_WIDTH-1:0]   i_cmd_id,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [1:0]            o_status,
    output logic [ID_WIDTH-1:0]   o_woken_id,
    output logic [TIME_WIDTH-1:0] o_ring_time,
    output logic                  o_last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCHED,
        S_INS,
        S_POP,
        S_END
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [TIME_WIDTH-1:0] r_cur;
    logic                  r_running;
    logic                  r_pop_all;
    logic [TIME_WIDTH-1:0] r_arg_time;
    logic [ID_WIDTH-1:0]   r_arg_id;
    logic [QUEUE_DEPTH-1:0] r_gt;
    logic [TIME_WIDTH-1:0] r_etime [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   r_eid   [QUEUE_DEPTH];

    logic                  r_out_valid;
    t_kind                 r_o_kind;
    t_status               r_o_status;
    logic [ID_WIDTH-1:0]   r_o_id;
    logic [TIME_WIDTH-1:0] r_o_time;
    logic                  r_o_last;

    logic                   out_free;
    logic                   res_load;
    logic                   head_due;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] prev_gt;
    logic [TIME_WIDTH:0]    sum;

    assign out_free  = !r_out_valid || !i_stall;
    // A new result is loaded into the output register this cycle.
    assign res_load  = out_free && ((r_state == S_SCHED &&
                                     (!r_running || r_count == CW'(QUEUE_DEPTH))) ||
                                    r_state == S_INS || r_state == S_POP ||
                                    r_state == S_END);
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign head_due  = (r_count != '0) && (r_pop_all || (r_etime[0] <= r_cur));
    assign sum       = {1'b0, r_cur} + {1'b0, i_cmd_time};
    assign prev_gt   = {r_gt[QUEUE_DEPTH-2:0], 1'b0};

    // Entries later than the new wake time; the list is sorted so this mask is a suffix.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (CW'(i) < r_count) && (r_etime[i] > r_arg_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_INS && out_free) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if ((CW'(i) == r_count || r_gt[i]) && !prev_gt[i]) begin
                    r_etime[i] <= r_arg_time;
                    r_eid[i]   <= r_arg_id;
                end else if (prev_gt[i] && CW'(i) <= r_count) begin
                    r_etime[i] <= r_etime[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    r_eid[i]   <= r_eid[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                end
            end
        end else if (r_state == S_POP && out_free && head_due) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_etime[i] <= r_etime[i + 1];
                r_eid[i]   <= r_eid[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_running   <= 1'b1;
            r_pop_all   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !res_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_arg_time <= i_cmd_time;
                        r_arg_id   <= i_cmd_id;
                        case (i_cmd_type)
                            REQ_SCHEDULE: begin
                                r_state <= S_SCHED;
                            end
                            REQ_ADVANCE: begin
                                r_cur     <= sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
                                r_pop_all <= 1'b0;
                                r_state   <= S_POP;
                            end
                            REQ_HALT: begin
                                r_running <= 1'b0;
                                r_pop_all <= 1'b1;
                                r_state   <= S_POP;
                            end
                            default: begin
                                r_cur   <= '0;
                                r_state <= S_END;
                            end
                        endcase
                    end
                end
                S_SCHED: begin
                    if (out_free) begin
                        if (!r_running || r_count == CW'(QUEUE_DEPTH)) begin
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_SCHED;
                            r_o_status  <= r_running ? STAT_FULL : STAT_HALTED;
                            r_o_id      <= '0;
                            r_o_time    <= '0;
                            r_o_last    <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_gt    <= gt;
                            r_state <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    if (out_free) begin
                        r_count     <= r_count + CW'(1);
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_SCHED;
                        r_o_status  <= STAT_OK;
                        r_o_id      <= '0;
                        r_o_time    <= '0;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= STAT_OK;
                        r_o_time    <= r_cur;
                        if (head_due) begin
                            r_count  <= r_count - CW'(1);
                            r_o_kind <= KIND_WAKE;
                            r_o_id   <= r_eid[0];
                            r_o_last <= 1'b0;
                        end else begin
                            r_o_kind <= KIND_END;
                            r_o_id   <= '0;
                            r_o_last <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_END: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_END;
                        r_o_status  <= STAT_OK;
                        r_o_id      <= '0;
                        r_o_time    <= r_cur;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_o_kind;
    assign o_status    = r_o_status;
    assign o_woken_id  = r_o_id;
    assign o_ring_time = r_o_time;
    assign o_last      = r_o_last;

endmodule

### sv/wakeup_timer_queue.sv
// Wakeup timer queue: the engine takes each transaction from its idle state. A schedule then
// passes the schedule and insert states (only the schedule state when refused), reset time the
// end state, advance and halt a pop loop giving one result per cycle unless the output stalls.
// Insertion compares the new time against every entry at once, then shifts in the insert state.
// Synchronous active-low reset: time 0, running, empty list, no queued transactions.
`include "wakeup_timer_queue_assert.svh"

module wakeup_timer_queue
    import wtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [TIME_WIDTH-1:0] i_wake_time,
    input  logic [ID_WIDTH-1:0]   i_requester_id,
    input  logic [TIME_WIDTH-1:0] i_time_increment,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [1:0]            o_status,
    output logic [ID_WIDTH-1:0]   o_woken_id,
    output logic [TIME_WIDTH-1:0] o_ring_time,
    output logic                  o_last
);

    // Commands handed from the front queue to the engine.
    logic                  cmd_valid;
    logic                  cmd_pop;
    t_req                  cmd_type;
    logic [TIME_WIDTH-1:0] cmd_time;
    logic [ID_WIDTH-1:0]   cmd_id;

    // The front absorbs up to two transactions so the sender is not held by a busy engine.
    wtq_front #(
        .TIME_WIDTH (TIME_WIDTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_wake_time      (i_wake_time),
        .i_requester_id   (i_requester_id),
        .i_time_increment (i_time_increment),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop),
        .o_cmd_type       (cmd_type),
        .o_cmd_time       (cmd_time),
        .o_cmd_id         (cmd_id)
    );

    // The engine owns the clock, the sorted list and the registered result.
    wtq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd_type  (cmd_type),
        .i_cmd_time  (cmd_time),
        .i_cmd_id    (cmd_id),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_status    (o_status),
        .o_woken_id  (o_woken_id),
        .o_ring_time (o_ring_time),
        .o_last      (o_last)
    );

    // Only wake notices are non-final; every other result closes its transaction.
    `WTQ_ASSERT_IMPLY(a_last_kind, o_valid, o_last == (o_kind != KIND_WAKE), "last flag mismatch")
    // A refusal status is only ever given with a schedule answer.
    `WTQ_ASSERT_IMPLY(a_status_kind, o_valid && o_kind != KIND_SCHED, o_status == STAT_OK,
        "status on non-schedule result")
    // Schedule answers carry no time and no id.
    `WTQ_ASSERT_IMPLY(a_sched_clean, o_valid && o_kind == KIND_SCHED,
        o_ring_time == '0 && o_woken_id == '0, "schedule answer carries data")
    // The engine never produces the unused kind code.
    `WTQ_ASSERT_NEVER(a_kind_code, o_valid && o_kind > KIND_END, "illegal result kind")

endmodule
